/* rtl/fsps_pkg.sv */
// ----------------------------------------------------------------------------
// fsps_pkg
// Shared types and codes for the searchable fifo: operation and status codes,
// field widths and the per-cell control group.
// ----------------------------------------------------------------------------
package fsps_pkg;

	localparam int OP_W   = 2;
	localparam int WORD_W = 32;
	localparam int POS_W  = 4;
	localparam int OCC_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_FIND = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic load;     // take the broadcast word (enqueue at the tail)
		logic shift;    // take the neighbor's word (dequeue)
		logic capture;  // latch the compare result (find start)
		logic scan;     // take the neighbor's hit flag (find scan)
		logic valid;    // cell holds a live entry
	} cell_ctrl_t;

endpackage

/* rtl/fsps_cell.sv */
// ----------------------------------------------------------------------------
// fsps_cell
// One queue slot: holds a word and a hit flag, loads from the broadcast bus
// or from its neighbor toward the tail, and hands its hit flag toward the head.
// ----------------------------------------------------------------------------
module fsps_cell
	import fsps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic signed [WORD_W-1:0] value,
	input  logic signed [WORD_W-1:0] next_word,
	input  logic                     next_hit,
	output logic signed [WORD_W-1:0] word,
	output logic                     hit
);

	logic signed [WORD_W-1:0] word_q;
	logic                     hit_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= value;
		end else if (ctrl.shift) begin
			word_q <= next_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.capture) begin
			hit_q <= ctrl.valid && (word_q == value);
		end else if (ctrl.scan) begin
			hit_q <= next_hit;
		end
	end

	assign word = word_q;
	assign hit  = hit_q;

endmodule

/* rtl/fifo_with_position_search.sv */
// ----------------------------------------------------------------------------
// fifo_with_position_search
// Bounded fifo of signed 32-bit words built as a row of cells, with search.
// ----------------------------------------------------------------------------
// Cell 0 always holds the head; a dequeue moves every word one cell toward the
// head and an enqueue writes the cell at the current fill level. Enqueue,
// dequeue and the unused op code give their result in the cycle after start and
// busy never rises. A find latches a compare flag in every cell, then walks the
// flags toward cell 0 one cell per cycle; a hit reports the position of the
// match nearest the head, a miss reports not found, and an empty queue gives
// not found without a walk. busy is high while the walk runs. Each result is
// shown for one cycle with done high and cannot be held off.
module fifo_with_position_search
	import fsps_pkg::*;
#(
	parameter int DEPTH = 16
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic signed [WORD_W-1:0] value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data,
	output logic [POS_W-1:0]         position,
	output logic [OCC_W-1:0]         occupancy
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	typedef enum logic {S_IDLE, S_SCAN} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         scan_q;
	logic signed [WORD_W-1:0] key_q;
	logic                     done_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] data_q;
	logic [POS_W-1:0]         position_q;
	logic [OCC_W-1:0]         occupancy_q;

	logic                     take;
	logic                     full;
	logic                     empty;
	logic                     last_scan;
	logic signed [WORD_W-1:0] words [DEPTH];
	logic                     hits  [DEPTH];
	cell_ctrl_t               ctrl  [DEPTH];

	assign take      = start && (state_q == S_IDLE);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign last_scan = ((CNT_W'(scan_q) + CNT_W'(1)) == count_q);

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic signed [WORD_W-1:0] nxt_word;
		logic                     nxt_hit;

		if (k == DEPTH - 1) begin : g_end
			assign nxt_word = '0;
			assign nxt_hit  = 1'b0;
		end else begin : g_mid
			assign nxt_word = words[k+1];
			assign nxt_hit  = hits[k+1];
		end

		always_comb begin
			ctrl[k].valid   = (CNT_W'(k) < count_q);
			ctrl[k].load    = take && (op_t'(op) == OP_ENQ) && (count_q == CNT_W'(k));
			ctrl[k].shift   = take && (op_t'(op) == OP_DEQ) && !empty;
			ctrl[k].capture = take && (op_t'(op) == OP_FIND);
			ctrl[k].scan    = (state_q == S_SCAN);
		end

		fsps_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[k]),
			.value     ((state_q == S_SCAN) ? key_q : value),
			.next_word (nxt_word),
			.next_hit  (nxt_hit),
			.word      (words[k]),
			.hit       (hits[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			key_q       <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			data_q      <= '0;
			position_q  <= '0;
			occupancy_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q   <= ST_OK;
						data_q     <= '0;
						position_q <= '0;
						case (op_t'(op))
							OP_ENQ: begin
								done_q <= 1'b1;
								if (full) begin
									status_q    <= ST_FULL;
									occupancy_q <= OCC_W'(count_q);
								end else begin
									count_q     <= count_q + CNT_W'(1);
									occupancy_q <= OCC_W'(count_q + CNT_W'(1));
								end
							end
							OP_DEQ: begin
								done_q <= 1'b1;
								if (empty) begin
									status_q    <= ST_EMPTY;
									occupancy_q <= OCC_W'(count_q);
								end else begin
									data_q      <= words[0];
									count_q     <= count_q - CNT_W'(1);
									occupancy_q <= OCC_W'(count_q - CNT_W'(1));
								end
							end
							OP_FIND: begin
								occupancy_q <= OCC_W'(count_q);
								key_q       <= value;
								scan_q      <= '0;
								if (empty) begin
									done_q   <= 1'b1;
									status_q <= ST_NOTFOUND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								done_q      <= 1'b1;
								occupancy_q <= OCC_W'(count_q);
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hits[0]) begin
						done_q     <= 1'b1;
						status_q   <= ST_OK;
						position_q <= POS_W'(scan_q);
						state_q    <= S_IDLE;
					end else if (last_scan) begin
						done_q     <= 1'b1;
						status_q   <= ST_NOTFOUND;
						position_q <= '0;
						state_q    <= S_IDLE;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q == S_SCAN);
	assign done      = done_q;
	assign status    = status_q;
	assign data      = data_q;
	assign position  = position_q;
	assign occupancy = occupancy_q;

endmodule

/* dv/fifo_search_checker.sv */
// ----------------------------------------------------------------------------
// fifo_search_checker
// Watches the command and result ports of the searchable fifo, keeps its own
// copy of the queue, predicts the result word of every accepted command and
// compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module fifo_search_checker
	import fsps_pkg::*;
#(
	parameter int DEPTH = 16
)
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic [OP_W-1:0]          op,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     done,
	input  logic [1:0]               status,
	input  logic signed [WORD_W-1:0] data,
	input  logic [POS_W-1:0]         position,
	input  logic [OCC_W-1:0]         occupancy,
	output int                       errors,
	output int                       outstanding
);

	typedef struct {
		status_t                  status;
		logic signed [WORD_W-1:0] data;
		logic [POS_W-1:0]         position;
		logic [OCC_W-1:0]         occupancy;
	} result_word_t;

	logic signed [WORD_W-1:0] held_words[$];
	result_word_t             expected_words[$];
	result_word_t             want;
	int                       fail_count = 0;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic result_word_t queue_operation(input logic [OP_W-1:0] code,
			input logic signed [WORD_W-1:0] word);
		result_word_t r;
		int           k;
		logic         hit;
		r.status = ST_OK;
		r.data = '0;
		r.position = '0;
		hit = 1'b0;
		case (code)
			OP_ENQ: begin
				if (held_words.size() >= DEPTH)
					r.status = ST_FULL;
				else
					held_words.push_back(word);
			end
			OP_DEQ: begin
				if (held_words.size() == 0)
					r.status = ST_EMPTY;
				else
					r.data = held_words.pop_front();
			end
			OP_FIND: begin
				for (k = 0; k < held_words.size() && !hit; k++) begin
					if (held_words[k] === word) begin
						hit = 1'b1;
						r.position = k[POS_W-1:0];
					end
				end
				if (!hit)
					r.status = ST_NOTFOUND;
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(held_words.size());
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			held_words.delete();
			expected_words.delete();
		end else begin
			if (done === 1'b1) begin
				if (expected_words.size() == 0) begin
					$error("result word with none expected: status %0d data %0d",
						status, data);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (data !== want.data) begin
						$error("data: expected %0d, actual %0d", want.data, data);
						fail_count++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, actual %0d", want.position,
							position);
						fail_count++;
					end
					if (occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, actual %0d", want.occupancy,
							occupancy);
						fail_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				expected_words.push_back(queue_operation(op, value));
		end
		errors <= fail_count;
		outstanding <= expected_words.size();
	end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the searchable fifo with a directed run over the special cases and
// then random phases of enqueue, dequeue, find and unused commands with
// varying sender gaps; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module testbench;
	import fsps_pkg::*;

	localparam int DEPTH = 16;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 212;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [OP_W-1:0]          op = OP_NOP;
	logic signed [WORD_W-1:0] value = '0;
	logic                     busy;
	logic                     done;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] data;
	logic [POS_W-1:0]         position;
	logic [OCC_W-1:0]         occupancy;
	int                       errors;
	int                       outstanding;

	logic signed [WORD_W-1:0] value_pool[8];

	fifo_with_position_search #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.value(value),
		.done(done),
		.status(status),
		.data(data),
		.position(position),
		.occupancy(occupancy)
	);

	fifo_search_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.value(value),
		.done(done),
		.status(status),
		.data(data),
		.position(position),
		.occupancy(occupancy),
		.errors(errors),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	task automatic issue_word(input logic [OP_W-1:0] code,
			input logic signed [WORD_W-1:0] word);
		start <= 1'b1;
		op <= code;
		value <= word;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [WORD_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return value_pool[$urandom_range(7)];
		if (r < 65) begin
			case ($urandom_range(3))
				0: return 32'sh7fff_ffff;
				1: return 32'sh8000_0000;
				2: return 32'sh0000_0000;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		int               phase;
		int               n;
		int               i;
		int               idle_pct;
		int               r;
		int               enq_cut;
		int               deq_cut;
		logic [OP_W-1:0]  code;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue cases and the unused code
		issue_word(OP_DEQ, 32'sd7);
		issue_word(OP_FIND, 32'sd0);
		issue_word(OP_NOP, -32'sd1);
		issue_word(OP_ENQ, 32'sh8000_0000);
		issue_word(OP_ENQ, 32'sh7fff_ffff);
		issue_word(OP_ENQ, 32'sd0);
		issue_word(OP_ENQ, -32'sd1);
		issue_word(OP_ENQ, 32'sd5);
		issue_word(OP_ENQ, 32'sd5);
		// duplicates report the one nearest the head
		issue_word(OP_FIND, 32'sd5);
		issue_word(OP_FIND, 32'sd42);
		issue_word(OP_FIND, 32'sh8000_0000);
		for (i = 0; i < 10; i++)
			issue_word(OP_ENQ, 32'sd100 + i);
		issue_word(OP_ENQ, 32'sd77);
		issue_word(OP_FIND, 32'sd109);
		issue_word(OP_NOP, 32'sh5555_aaaa);
		issue_word(OP_DEQ, 32'sd0);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: idle_pct = 0;
				1: idle_pct = 62;
				2: idle_pct = 0;
				default: idle_pct = 15;
			endcase
			// alternate between filling and draining the queue
			enq_cut = (phase % 2 == 0) ? 50 : 25;
			deq_cut = (phase % 2 == 0) ? 70 : 70;
			for (i = 0; i < 8; i++)
				value_pool[i] = (i < 2) ? $urandom_range(3) : $urandom;
			for (n = 0; n < WORDS_PER_PHASE; n++) begin
				r = $urandom_range(99);
				if (r < enq_cut)
					code = OP_ENQ;
				else if (r < deq_cut)
					code = OP_DEQ;
				else if (r < 95)
					code = OP_FIND;
				else
					code = OP_NOP;
				issue_word(code, pick_value());
				if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					do @(posedge clk); while ($urandom_range(99) < idle_pct);
				end
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
